FILE: hdl/psq_pkg.sv
// shared types, constants and scale tables for the pitch scale quantizer
package psq_pkg;

   // fixed field widths
   localparam int NOTE_W        = 16;
   localparam int CFG_W         = 4;
   localparam int CSR_IDX_W     = 2;
   localparam int FRAC_BITS_DEF = 8;

   // output saturation limits
   localparam int OUT_MAX = 32767;
   localparam int OUT_MIN = -32768;

   // scale tables
   localparam int NUM_SCALES = 10;
   localparam int NUM_PC     = 12;

   // configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_KEY_ROOT   = 2'd0,
      CSR_SCALE_MODE = 2'd1,
      CSR_SNAP_MODE  = 2'd2
   } csr_index_type;

   // snap mode codes, the unnamed code acts as free
   typedef enum logic [1:0] {
      SNAP_CHROM = 2'd0,
      SNAP_SCALE = 2'd1,
      SNAP_FREE  = 2'd2
   } snap_mode_type;

   // highest scale degree at or below each pitch class
   localparam logic [3:0] FLOOR_TBL [NUM_SCALES][NUM_PC] = '{
      '{4'd0, 4'd0, 4'd2, 4'd2, 4'd4, 4'd5, 4'd5, 4'd7, 4'd7, 4'd9, 4'd9, 4'd11},
      '{4'd0, 4'd0, 4'd2, 4'd3, 4'd3, 4'd5, 4'd5, 4'd7, 4'd8, 4'd8, 4'd10, 4'd10},
      '{4'd0, 4'd0, 4'd2, 4'd3, 4'd3, 4'd5, 4'd5, 4'd7, 4'd7, 4'd9, 4'd10, 4'd10},
      '{4'd0, 4'd0, 4'd2, 4'd2, 4'd4, 4'd5, 4'd5, 4'd7, 4'd7, 4'd9, 4'd10, 4'd10},
      '{4'd0, 4'd0, 4'd0, 4'd3, 4'd3, 4'd5, 4'd5, 4'd7, 4'd7, 4'd7, 4'd10, 4'd10},
      '{4'd0, 4'd0, 4'd0, 4'd3, 4'd3, 4'd5, 4'd6, 4'd7, 4'd7, 4'd7, 4'd10, 4'd10},
      '{4'd0, 4'd0, 4'd2, 4'd3, 4'd3, 4'd5, 4'd5, 4'd7, 4'd8, 4'd8, 4'd8, 4'd11},
      '{4'd0, 4'd0, 4'd2, 4'd3, 4'd3, 4'd5, 4'd5, 4'd7, 4'd7, 4'd9, 4'd9, 4'd11},
      '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd10, 4'd11},
      '{4'd0, 4'd0, 4'd2, 4'd2, 4'd4, 4'd4, 4'd4, 4'd7, 4'd7, 4'd9, 4'd9, 4'd9}
   };

   // next scale degree above the floor degree, 12 is the next octave root
   localparam logic [3:0] NEXT_TBL [NUM_SCALES][NUM_PC] = '{
      '{4'd2, 4'd2, 4'd4, 4'd4, 4'd5, 4'd7, 4'd7, 4'd9, 4'd9, 4'd11, 4'd11, 4'd12},
      '{4'd2, 4'd2, 4'd3, 4'd5, 4'd5, 4'd7, 4'd7, 4'd8, 4'd10, 4'd10, 4'd12, 4'd12},
      '{4'd2, 4'd2, 4'd3, 4'd5, 4'd5, 4'd7, 4'd7, 4'd9, 4'd9, 4'd10, 4'd12, 4'd12},
      '{4'd2, 4'd2, 4'd4, 4'd4, 4'd5, 4'd7, 4'd7, 4'd9, 4'd9, 4'd10, 4'd12, 4'd12},
      '{4'd3, 4'd3, 4'd3, 4'd5, 4'd5, 4'd7, 4'd7, 4'd10, 4'd10, 4'd10, 4'd12, 4'd12},
      '{4'd3, 4'd3, 4'd3, 4'd5, 4'd5, 4'd6, 4'd7, 4'd10, 4'd10, 4'd10, 4'd12, 4'd12},
      '{4'd2, 4'd2, 4'd3, 4'd5, 4'd5, 4'd7, 4'd7, 4'd8, 4'd11, 4'd11, 4'd11, 4'd12},
      '{4'd2, 4'd2, 4'd3, 4'd5, 4'd5, 4'd7, 4'd7, 4'd9, 4'd9, 4'd11, 4'd11, 4'd12},
      '{4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd10, 4'd11, 4'd12},
      '{4'd2, 4'd2, 4'd4, 4'd4, 4'd7, 4'd7, 4'd7, 4'd9, 4'd9, 4'd12, 4'd12, 4'd12}
   };

   // top degree of each scale
   localparam logic [3:0] LAST_TBL [NUM_SCALES] = '{
      4'd11, 4'd10, 4'd10, 4'd10, 4'd10, 4'd10, 4'd11, 4'd11, 4'd11, 4'd9
   };

   function automatic logic [3:0] scale_floor(input logic [3:0] sel, input logic [3:0] pc);
      return FLOOR_TBL[sel][pc];
   endfunction

   function automatic logic [3:0] scale_next(input logic [3:0] sel, input logic [3:0] pc);
      return NEXT_TBL[sel][pc];
   endfunction

   function automatic logic [3:0] scale_last(input logic [3:0] sel);
      return LAST_TBL[sel];
   endfunction

endpackage

FILE: hdl/pitch_scale_quantizer_core.sv
// pitch scale quantizer: four-stage pipeline snapping a fixed-point note
// One note word enters per cycle and one snapped word leaves per cycle while the output
// side does not stall. Each word passes four register stages (split, octave divide,
// scale pick, scale and saturate) before its result shows on rsp_valid. Each stage holds
// on its own, so bubbles are squeezed out under backpressure and a new word is taken
// while a finished one still waits. Configuration registers are read live by the
// pipeline and may change only while it is empty.
module pitch_scale_quantizer_core #(
   parameter int FRAC_BITS = psq_pkg::FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // note words in
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [psq_pkg::NOTE_W-1:0]   req_note_in,
   // snapped words out
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [psq_pkg::NOTE_W-1:0]   rsp_note_out,
   // register writes
   input  logic                                csr_we,
   input  logic [psq_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [psq_pkg::CFG_W-1:0]           csr_wdata
);

   localparam int NW = psq_pkg::NOTE_W;
   localparam int DW = FRAC_BITS + 8;
   localparam int SW = NW + 1 + FRAC_BITS;
   localparam logic [3:0] QQ_TOP  = 4'd12;
   localparam logic [3:0] DEG_OCT = 4'd12;

   // configuration registers
   logic [3:0] key_root_ff, scale_mode_ff;
   logic [1:0] snap_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_root_ff   <= '0;
         scale_mode_ff <= '0;
         snap_mode_ff  <= psq_pkg::SNAP_SCALE;
      end else if (csr_we) begin
         case (csr_index)
            psq_pkg::CSR_KEY_ROOT:   key_root_ff   <= csr_wdata;
            psq_pkg::CSR_SCALE_MODE: scale_mode_ff <= csr_wdata;
            psq_pkg::CSR_SNAP_MODE:  snap_mode_ff  <= csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   // stage valids and per-stage load enables
   logic s1_v_ff, s2_v_ff, s3_v_ff, s4_v_ff;
   logic s1_en, s2_en, s3_en, s4_en;

   assign s4_en     = !s4_v_ff || rsp_ready;
   assign s3_en     = !s3_v_ff || s4_en;
   assign s2_en     = !s2_v_ff || s3_en;
   assign s1_en     = !s1_v_ff || s2_en;
   assign req_ready = s1_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
         s4_v_ff <= 1'b0;
      end else begin
         if (s1_en) s1_v_ff <= req_valid;
         if (s2_en) s2_v_ff <= s1_v_ff;
         if (s3_en) s3_v_ff <= s2_v_ff;
         if (s4_en) s4_v_ff <= s3_v_ff;
      end
   end

   // stage 1: whole part, fraction, rounding bit, offset from root
   logic signed [NW-1:0]  m_s1_in;
   logic [FRAC_BITS-1:0]  r_s1_in;
   logic signed [NW:0]    t_s1;
   logic                  rnd_s1_in, below_s1_in, above_s1_in;
   logic [7:0]            u_s1_in;

   always_comb begin
      m_s1_in     = req_note_in >>> FRAC_BITS;
      r_s1_in     = req_note_in[FRAC_BITS-1:0];
      // halves round away from zero
      rnd_s1_in   = req_note_in[NW-1] ? (r_s1_in[FRAC_BITS-1] & (|r_s1_in[FRAC_BITS-2:0]))
                                      : r_s1_in[FRAC_BITS-1];
      t_s1        = {m_s1_in[NW-1], m_s1_in} - {{(NW-3){1'b0}}, key_root_ff};
      below_s1_in = t_s1 < -(NW+1)'(24);
      above_s1_in = t_s1 > (NW+1)'(131);
      u_s1_in     = 8'(t_s1 + (NW+1)'(24));
   end

   logic signed [NW-1:0] s1_x_ff, s1_m_ff;
   logic [FRAC_BITS-1:0] s1_r_ff;
   logic                 s1_rnd_ff, s1_below_ff, s1_above_ff;
   logic [7:0]           s1_u_ff;

   always_ff @(posedge clock) begin
      if (s1_en) begin
         s1_x_ff     <= req_note_in;
         s1_m_ff     <= m_s1_in;
         s1_r_ff     <= r_s1_in;
         s1_rnd_ff   <= rnd_s1_in;
         s1_below_ff <= below_s1_in;
         s1_above_ff <= above_s1_in;
         s1_u_ff     <= u_s1_in;
      end
   end

   // stage 2: octave and pitch class by reciprocal multiply
   logic [15:0] prod_s2;
   logic [3:0]  qq_s2_in, p_s2_in;
   logic [7:0]  pw_s2;

   always_comb begin
      prod_s2  = 16'(s1_u_ff) * 16'd171;
      qq_s2_in = 4'(prod_s2 >> 11);
      pw_s2    = s1_u_ff - {1'b0, qq_s2_in, 3'b000} - {2'b00, qq_s2_in, 2'b00};
      p_s2_in  = pw_s2[3:0];
   end

   logic signed [NW-1:0] s2_x_ff, s2_m_ff;
   logic [FRAC_BITS-1:0] s2_r_ff;
   logic                 s2_rnd_ff, s2_below_ff, s2_above_ff;
   logic [3:0]           s2_qq_ff, s2_p_ff;

   always_ff @(posedge clock) begin
      if (s2_en) begin
         s2_x_ff     <= s1_x_ff;
         s2_m_ff     <= s1_m_ff;
         s2_r_ff     <= s1_r_ff;
         s2_rnd_ff   <= s1_rnd_ff;
         s2_below_ff <= s1_below_ff;
         s2_above_ff <= s1_above_ff;
         s2_qq_ff    <= qq_s2_in;
         s2_p_ff     <= p_s2_in;
      end
   end

   // stage 3: pick the nearer neighbor degree and select the mode
   logic [3:0]            sel_s3, fd_s3, nd_s3, last_s3;
   logic signed [6:0]     d_s3;
   logic signed [DW-1:0]  lhs_s3, twice_r_s3;
   logic                  pick_hi_s3, free_s3_in;
   logic [7:0]            oct12_s3, off_s3;
   logic signed [NW:0]    scale_note_s3, chrom_note_s3, n_s3_in;

   always_comb begin
      sel_s3   = (scale_mode_ff < 4'(psq_pkg::NUM_SCALES)) ? scale_mode_ff : 4'd0;
      fd_s3    = psq_pkg::scale_floor(sel_s3, s2_p_ff);
      nd_s3    = psq_pkg::scale_next(sel_s3, s2_p_ff);
      last_s3  = psq_pkg::scale_last(sel_s3);
      // upper wins only when strictly nearer: (nd + fd - 2p) * one < 2r
      d_s3       = 7'({3'b000, nd_s3}) + 7'({3'b000, fd_s3}) - 7'({2'b00, s2_p_ff, 1'b0});
      lhs_s3     = DW'(d_s3) <<< FRAC_BITS;
      twice_r_s3 = DW'({s2_r_ff, 1'b0});
      pick_hi_s3 = lhs_s3 < twice_r_s3;
      oct12_s3   = {1'b0, s2_qq_ff, 3'b000} + {2'b00, s2_qq_ff, 2'b00};
      // offset above root minus two octaves, clamped to the candidate span
      if (s2_below_ff)
         off_s3 = 8'd0;
      else if (s2_above_ff)
         off_s3 = 8'({4'd0, last_s3}) + 8'd144;
      else if (pick_hi_s3 && !(s2_qq_ff == QQ_TOP && nd_s3 == DEG_OCT))
         off_s3 = oct12_s3 + {4'd0, nd_s3};
      else
         off_s3 = oct12_s3 + {4'd0, fd_s3};
      scale_note_s3 = {{(NW-3){1'b0}}, key_root_ff} + {{(NW-7){1'b0}}, off_s3}
                      - (NW+1)'(24);
      chrom_note_s3 = {s2_m_ff[NW-1], s2_m_ff} + {{NW{1'b0}}, s2_rnd_ff};
      free_s3_in    = 1'b0;
      case (snap_mode_ff)
         psq_pkg::SNAP_CHROM: n_s3_in = chrom_note_s3;
         psq_pkg::SNAP_SCALE: n_s3_in = scale_note_s3;
         default: begin
            n_s3_in    = chrom_note_s3;
            free_s3_in = 1'b1;
         end
      endcase
   end

   logic signed [NW-1:0] s3_x_ff;
   logic signed [NW:0]   s3_n_ff;
   logic                 s3_free_ff;

   always_ff @(posedge clock) begin
      if (s3_en) begin
         s3_x_ff    <= s2_x_ff;
         s3_n_ff    <= n_s3_in;
         s3_free_ff <= free_s3_in;
      end
   end

   // stage 4: back to fixed point with saturation
   logic signed [SW-1:0] wide_s4;
   logic signed [NW-1:0] out_s4_in;

   always_comb begin
      wide_s4 = SW'(s3_n_ff) <<< FRAC_BITS;
      if (s3_free_ff)
         out_s4_in = s3_x_ff;
      else if (wide_s4 > SW'(psq_pkg::OUT_MAX))
         out_s4_in = NW'(psq_pkg::OUT_MAX);
      else if (wide_s4 < SW'(psq_pkg::OUT_MIN))
         out_s4_in = NW'(psq_pkg::OUT_MIN);
      else
         out_s4_in = wide_s4[NW-1:0];
   end

   logic signed [NW-1:0] s4_note_ff;

   always_ff @(posedge clock) begin
      if (s4_en) s4_note_ff <= out_s4_in;
   end

   assign rsp_valid    = s4_v_ff;
   assign rsp_note_out = s4_note_ff;

endmodule

FILE: hdl/psq_checker.sv
// port-level checks for the pitch scale quantizer and their bind
module psq_checker #(
   parameter int FRAC_BITS = psq_pkg::FRAC_BITS_DEF
) (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic signed [psq_pkg::NOTE_W-1:0]  rsp_note_out,
   input logic                               csr_we,
   input logic [psq_pkg::CSR_IDX_W-1:0]      csr_index,
   input logic [psq_pkg::CFG_W-1:0]          csr_wdata
);

   logic       in_acc, out_acc, grid_mode;
   logic [2:0] inflight_ff;
   logic [1:0] snap_ff;

   assign in_acc    = req_valid && req_ready;
   assign out_acc   = rsp_valid && rsp_ready;
   assign grid_mode = (snap_ff == psq_pkg::SNAP_CHROM) || (snap_ff == psq_pkg::SNAP_SCALE);

   // words inside the block
   always_ff @(posedge clock) begin
      if (reset)
         inflight_ff <= '0;
      else if (in_acc && !out_acc)
         inflight_ff <= inflight_ff + 3'd1;
      else if (out_acc && !in_acc)
         inflight_ff <= inflight_ff - 3'd1;
   end

   // shadow of the snap mode register
   always_ff @(posedge clock) begin
      if (reset)
         snap_ff <= psq_pkg::SNAP_SCALE;
      else if (csr_we && csr_index == psq_pkg::CSR_SNAP_MODE)
         snap_ff <= csr_wdata[1:0];
   end

   // a held result keeps its value
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_note_out))
      else $error("result changed while stalled");

   // pipeline comes out of reset empty and ready
   a_reset: assert property (@(posedge clock)
      reset |=> req_ready && !rsp_valid)
      else $error("pipeline not empty after reset");

   // no result without a word inside
   a_no_extra: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> inflight_ff != 3'd0)
      else $error("result with no word in flight");

   // at most four words fit in the pipeline
   a_depth: assert property (@(posedge clock) disable iff (reset)
      inflight_ff <= 3'd4)
      else $error("more words in flight than stages");

   // snapped results sit on whole notes unless saturated
   a_grid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && grid_mode |->
         rsp_note_out[FRAC_BITS-1:0] == '0 ||
         rsp_note_out == psq_pkg::NOTE_W'(psq_pkg::OUT_MAX) ||
         rsp_note_out == psq_pkg::NOTE_W'(psq_pkg::OUT_MIN))
      else $error("snapped result off the note grid");

endmodule

bind pitch_scale_quantizer_core psq_checker #(.FRAC_BITS(FRAC_BITS)) u_psq_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_ready    (req_ready),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_note_out (rsp_note_out),
   .csr_we       (csr_we),
   .csr_index    (csr_index),
   .csr_wdata    (csr_wdata)
);

FILE: verif/psq_snap_monitor.sv
// monitor for the pitch scale quantizer: tracks registers, predicts snapped notes, compares
`timescale 1ns / 100ps

module psq_snap_monitor #(
   parameter int FRAC_BITS = psq_pkg::FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_ready,
   input  logic signed [psq_pkg::NOTE_W-1:0] req_note_in,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  logic signed [psq_pkg::NOTE_W-1:0] rsp_note_out,
   input  logic                              csr_we,
   input  logic [psq_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [psq_pkg::CFG_W-1:0]         csr_wdata,
   output int                                words_pending,
   output int                                fail_count
);

   // scale codes
   localparam logic [3:0] SCALE_MAJOR      = 4'd0;
   localparam logic [3:0] SCALE_MINOR      = 4'd1;
   localparam logic [3:0] SCALE_DORIAN     = 4'd2;
   localparam logic [3:0] SCALE_MIXOLYDIAN = 4'd3;
   localparam logic [3:0] SCALE_PENTATONIC = 4'd4;
   localparam logic [3:0] SCALE_BLUES      = 4'd5;
   localparam logic [3:0] SCALE_HARMONIC   = 4'd6;
   localparam logic [3:0] SCALE_MELODIC    = 4'd7;
   localparam logic [3:0] SCALE_CHROMATIC  = 4'd8;
   localparam logic [3:0] SCALE_CUSTOM     = 4'd9;

   localparam int REPORT_MAX = 10;

   typedef struct {
      logic signed [psq_pkg::NOTE_W-1:0] note_in;
      logic signed [psq_pkg::NOTE_W-1:0] note_out;
   } snap_pair_type;

   snap_pair_type snapped_notes[$];
   logic [3:0]    key_root;
   logic [3:0]    scale_mode;
   logic [1:0]    snap_mode;
   int            note_faults = 0;

   // pitch classes present in each scale, bit n is pitch class n above the root
   function automatic logic [11:0] scale_mask(input logic [3:0] sel);
      case (sel)
         SCALE_MINOR:      return 12'b0101_1010_1101;
         SCALE_DORIAN:     return 12'b0110_1010_1101;
         SCALE_MIXOLYDIAN: return 12'b0110_1011_0101;
         SCALE_PENTATONIC: return 12'b0100_1010_1001;
         SCALE_BLUES:      return 12'b0100_1110_1001;
         SCALE_HARMONIC:   return 12'b1001_1010_1101;
         SCALE_MELODIC:    return 12'b1010_1010_1101;
         SCALE_CHROMATIC:  return 12'b1111_1111_1111;
         SCALE_CUSTOM:     return 12'b0010_1001_0101;
         default:          return 12'b1010_1011_0101;   // major, also for unknown codes
      endcase
   endfunction

   // snapped note for one input word under the given register values
   function automatic logic signed [psq_pkg::NOTE_W-1:0] snap_note(
      input logic signed [psq_pkg::NOTE_W-1:0] note,
      input logic [3:0]                        root,
      input logic [3:0]                        scale,
      input logic [1:0]                        snap
   );
      longint     x;
      longint     one;
      longint     half;
      longint     whole;
      longint     y;
      longint     best;
      longint     best_gap;
      longint     cand;
      longint     gap;
      logic [11:0] mask;
      bit         found;
      x    = note;
      one  = longint'(1) << FRAC_BITS;
      half = one / 2;
      y    = x;
      case (snap)
         psq_pkg::SNAP_CHROM: begin
            // round half away from zero
            if (x >= 0)
               whole = (x + half) / one;
            else
               whole = -((-x + half) / one);
            y = whole * one;
         end
         psq_pkg::SNAP_SCALE: begin
            // ascending walk over candidates, strict compare keeps the lower on a tie
            mask     = scale_mask(scale);
            found    = 1'b0;
            best     = 0;
            best_gap = 0;
            for (int oct = -2; oct <= 10; oct++) begin
               for (int pc = 0; pc < 12; pc++) begin
                  if (mask[pc]) begin
                     cand = (longint'(root) + pc + oct * 12) * one;
                     gap  = cand - x;
                     if (gap < 0)
                        gap = -gap;
                     if (!found || gap < best_gap) begin
                        found    = 1'b1;
                        best_gap = gap;
                        best     = cand;
                     end
                  end
               end
            end
            y = best;
         end
         default: y = x;   // free and the unnamed code pass through
      endcase
      // saturate to the output word
      if (y > psq_pkg::OUT_MAX)
         y = psq_pkg::OUT_MAX;
      else if (y < psq_pkg::OUT_MIN)
         y = psq_pkg::OUT_MIN;
      return y[psq_pkg::NOTE_W-1:0];
   endfunction

   // register shadow, prediction and comparison
   always @(posedge clock) begin
      snap_pair_type pair;
      if (reset) begin
         key_root   = 4'd0;
         scale_mode = SCALE_MAJOR;
         snap_mode  = psq_pkg::SNAP_SCALE;
         snapped_notes.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               psq_pkg::CSR_KEY_ROOT:   key_root   = csr_wdata;
               psq_pkg::CSR_SCALE_MODE: scale_mode = csr_wdata;
               psq_pkg::CSR_SNAP_MODE:  snap_mode  = csr_wdata[1:0];
               default: ;
            endcase
         end
         // result word leaving the block
         if (rsp_valid && rsp_ready) begin
            if (snapped_notes.size() == 0) begin
               note_faults++;
               if (note_faults <= REPORT_MAX)
                  $display("%0t: unexpected note word %0d with nothing pending",
                           $realtime, rsp_note_out);
            end else begin
               pair = snapped_notes.pop_front();
               if (rsp_note_out !== pair.note_out) begin
                  note_faults++;
                  if (note_faults <= REPORT_MAX)
                     $display("%0t: note_out mismatch for note_in %0d: expected %0d got %0d",
                              $realtime, pair.note_in, pair.note_out, rsp_note_out);
               end
            end
         end
         // note word entering the block
         if (req_valid && req_ready) begin
            pair.note_in  = req_note_in;
            pair.note_out = snap_note(req_note_in, key_root, scale_mode, snap_mode);
            snapped_notes.push_back(pair);
         end
      end
      words_pending <= snapped_notes.size();
      fail_count    <= note_faults;
   end

endmodule

FILE: verif/tb.sv
// top of the pitch scale quantizer bench: clock, reset, stimulus and verdict
`timescale 1ns / 100ps

module tb;

   localparam int FRAC_BITS      = psq_pkg::FRAC_BITS_DEF;
   localparam int RAND_PHASES    = 16;
   localparam int QUIET_PHASES   = 3;
   localparam int HOLD_CYCLES    = 200;
   localparam int DRAIN_CYCLES   = 8;
   localparam int WATCHDOG_LIMIT = 2000;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_valid = 1'b0;
   logic                                req_ready;
   logic signed [psq_pkg::NOTE_W-1:0]   req_note_in = '0;
   logic                                rsp_valid;
   logic                                rsp_ready = 1'b0;
   logic signed [psq_pkg::NOTE_W-1:0]   rsp_note_out;
   logic                                csr_we = 1'b0;
   logic [psq_pkg::CSR_IDX_W-1:0]       csr_index = psq_pkg::CSR_KEY_ROOT;
   logic [psq_pkg::CFG_W-1:0]           csr_wdata = '0;

   logic idle_on = 1'b1;
   logic hold_go = 1'b0;
   int   words_pending;
   int   fail_count;
   int   quiet_cycles = 0;

   // clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   pitch_scale_quantizer_core #(.FRAC_BITS(FRAC_BITS)) u_top (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_note_in  (req_note_in),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_note_out (rsp_note_out),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   psq_snap_monitor #(.FRAC_BITS(FRAC_BITS)) u_monitor (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_note_in   (req_note_in),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_note_out  (rsp_note_out),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .words_pending (words_pending),
      .fail_count    (fail_count)
   );

   // watchdog on cycles with no word moving on either side
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // output side: random stall bursts, one long hold-off when asked
   initial begin
      bit hold_done;
      hold_done = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_go && !hold_done) begin
            hold_done = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_ready <= 1'b1;
         end else if (idle_on && rsp_ready && $urandom_range(0, 7) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // offer one note word, valid stays up across back-to-back words
   task automatic send_note(input logic [psq_pkg::NOTE_W-1:0] note);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_note_in <= note;
      do @(posedge clock); while (!(req_valid && req_ready));
   endtask

   // wait until every snapped word is back, then a further drain margin
   task automatic drain_all();
      req_valid <= 1'b0;
      do @(posedge clock); while (words_pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // write all three registers on consecutive cycles
   task automatic write_cfg(input logic [3:0] key, input logic [3:0] scale,
                            input logic [3:0] snap);
      csr_we    <= 1'b1;
      csr_index <= psq_pkg::CSR_KEY_ROOT;
      csr_wdata <= key;
      @(posedge clock);
      csr_index <= psq_pkg::CSR_SCALE_MODE;
      csr_wdata <= scale;
      @(posedge clock);
      csr_index <= psq_pkg::CSR_SNAP_MODE;
      csr_wdata <= snap;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // note values: full range, musical range around grid points and halves, rails
   function automatic logic [psq_pkg::NOTE_W-1:0] pick_note();
      int semis;
      int frac;
      case ($urandom_range(0, 9))
         0, 1, 2: return psq_pkg::NOTE_W'($urandom);
         8: begin
            if ($urandom_range(0, 1))
               return psq_pkg::NOTE_W'(psq_pkg::OUT_MAX - int'($urandom_range(0, 600)));
            return psq_pkg::NOTE_W'(psq_pkg::OUT_MIN + int'($urandom_range(0, 600)));
         end
         default: begin
            semis = int'($urandom_range(0, 167)) - 40;
            case ($urandom_range(0, 3))
               0:       frac = 0;
               1:       frac = 1 << (FRAC_BITS - 1);
               2:       frac = ((1 << (FRAC_BITS - 1)) - 1) + 2 * int'($urandom_range(0, 1));
               default: frac = $urandom_range(0, (1 << FRAC_BITS) - 1);
            endcase
            return psq_pkg::NOTE_W'((semis << FRAC_BITS) + frac);
         end
      endcase
   endfunction

   // stimulus
   initial begin
      logic [3:0] key;
      logic [3:0] scale;
      logic [1:0] snap;
      int         pick;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset setting: snap to C major; rails, ties and the bottom of the span
      send_note(16'h8000);
      send_note(16'h7FFF);
      send_note(16'h0000);
      send_note(16'h0080);
      send_note(16'h0300);
      send_note(16'hE7FF);
      drain_all();

      // chromatic rounding: halves both signs, saturation at the top
      write_cfg(4'd0, 4'd0, psq_pkg::SNAP_CHROM);
      send_note(16'h0080);
      send_note(16'hFF80);
      send_note(16'h7FFF);
      send_note(16'h8000);
      send_note(16'h017F);
      send_note(16'hFE81);
      drain_all();

      // free pass-through with out-of-range root and scale
      write_cfg('1, '1, psq_pkg::SNAP_FREE);
      send_note(16'h1234);
      send_note(16'h8000);
      drain_all();

      // unnamed snap code passes through
      write_cfg(4'd0, 4'd0, '1);
      send_note(16'h7FFF);
      send_note(16'hABCD);
      drain_all();

      // root beyond the octave and unknown scale fall back to major, shifted
      write_cfg('1, '1, psq_pkg::SNAP_SCALE);
      send_note(16'h7FFF);
      send_note(16'h8000);
      send_note(16'h0000);
      send_note(16'h0F00);
      drain_all();

      // random phases, every scale code visited once in order
      for (int ph = 0; ph < RAND_PHASES; ph++) begin
         if (ph == RAND_PHASES - QUIET_PHASES)
            idle_on <= 1'b0;
         if (ph == 2)
            hold_go <= 1'b1;
         key   = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(12, 15))
                                             : 4'($urandom_range(0, 11));
         scale = 4'(ph);
         pick  = $urandom_range(0, 9);
         if (pick < 6)
            snap = psq_pkg::SNAP_SCALE;
         else if (pick < 8)
            snap = psq_pkg::SNAP_CHROM;
         else if (pick == 8)
            snap = psq_pkg::SNAP_FREE;
         else
            snap = '1;
         write_cfg(key, scale, {2'($urandom_range(0, 3)), snap});
         repeat ($urandom_range(40, 64)) send_note(pick_note());
         drain_all();
      end

      if (fail_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

FILE: pitch_scale_quantizer_core.f
hdl/psq_pkg.sv
hdl/pitch_scale_quantizer_core.sv
hdl/psq_checker.sv
verif/psq_snap_monitor.sv
verif/tb.sv
